/* design/scds_pkg.sv */
// Package for the serial clock divider search.
// Holds shared widths, default parameter values, reset constants and the
// controller state type. No dependencies.
package scds_pkg;

  // Field widths fixed by the interface
  localparam int DATA_W      = 32;
  localparam int PRESCALE_W  = 3;
  localparam int DIVEXP_W    = 4;

  // Default search bounds
  localparam int PRESCALE_MAX_DEF    = 7;
  localparam int DIVIDER_EXP_MAX_DEF = 8;

  // Reset value of the clock frequency register (Hz)
  localparam logic [DATA_W-1:0] CLOCK_FREQ_RESET = 32'd48000000;

  // Starting value of every running minimum
  localparam logic [DATA_W-1:0] SHORT_INIT = 32'hFFFF_FFFF;

  // Search controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEED,
    ST_WAIT,
    ST_HOLD
  } scds_state_t;

endpackage

/* design/scds_div_cell.sv */
// One restoring-division step of the quotient pipeline.
// Produces one quotient bit per cell; divisor is the prescaler code plus one.
// Depends on nothing outside this file.
module scds_div_cell #(
  parameter int PW = 3,
  parameter int RW = 4,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [PW-1:0] in_p,
  input  logic [RW-1:0] in_rem,
  input  logic [DW-1:0] in_num,
  output logic          out_valid,
  output logic [PW-1:0] out_p,
  output logic [RW-1:0] out_rem,
  output logic [DW-1:0] out_num
);

  logic [RW:0]   trial;
  logic [RW:0]   den;
  logic          ge;
  logic [RW-1:0] rem_next;
  logic [DW-1:0] num_next;

  // Shift in next dividend bit, compare and subtract
  always_comb begin
    trial    = {in_rem, in_num[DW-1]};
    den      = (RW+1)'(in_p) + (RW+1)'(1);
    ge       = (trial >= den);
    rem_next = ge ? RW'(trial - den) : RW'(trial);
    num_next = {in_num[DW-2:0], ge};
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    out_p   <= in_p;
    out_rem <= rem_next;
    out_num <= num_next;
  end

endmodule

/* design/scds_cmp_cell.sv */
// One divider-exponent position of the candidate compare chain.
// Scores the candidate rate for exponent D against the target and keeps the
// best exponent seen for this prescaler code. No outside dependencies.
module scds_cmp_cell #(
  parameter int PW  = 3,
  parameter int DXW = 4,
  parameter int DW  = 32,
  parameter int D   = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [DW-1:0]  target,
  input  logic           in_valid,
  input  logic [PW-1:0]  in_p,
  input  logic [DW-1:0]  in_q,
  input  logic [DW-1:0]  in_min,
  input  logic [DXW-1:0] in_d,
  output logic           out_valid,
  output logic [PW-1:0]  out_p,
  output logic [DW-1:0]  out_q,
  output logic [DW-1:0]  out_min,
  output logic [DXW-1:0] out_d
);

  logic [DW-1:0] shortfall;
  logic          take;

  // Candidate counts only if not above target; strictly better wins
  always_comb begin
    shortfall = target - in_q;
    take      = (target >= in_q) && (shortfall < in_min);
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // Payload; next exponent halves the candidate
  always_ff @(posedge clk) begin
    out_p   <= in_p;
    out_q   <= in_q >> 1;
    out_min <= take ? shortfall : in_min;
    out_d   <= take ? DXW'(D) : in_d;
  end

endmodule

/* design/spi_clock_divider_search.sv */
// Serial clock divider search, top level.
// Pipeline: one feed per prescaler code, the divider cells, (DIVIDER_EXP_MAX+1)
// compare cells, merge and output register.
// One request at a time; the next can be taken as soon as the result is in the output
// register; a stalled result holds off the next load.
// Reset (synchronous, rst high) clears control state and loads 48 MHz clock.
module spi_clock_divider_search
  import scds_pkg::*;
#(
  parameter int PRESCALE_MAX    = PRESCALE_MAX_DEF,
  parameter int DIVIDER_EXP_MAX = DIVIDER_EXP_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clock_frequency_we,
  input  logic [DATA_W-1:0]     clock_frequency,
  input  logic                  target_valid,
  output logic                  target_stall,
  input  logic [DATA_W-1:0]     target_rate,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [PRESCALE_W-1:0] prescale_select,
  output logic [DIVEXP_W-1:0]   divider_exponent
);

  localparam int PW        = $clog2(PRESCALE_MAX + 1);
  localparam int RW        = $clog2(PRESCALE_MAX + 2);
  localparam int DXW       = $clog2(DIVIDER_EXP_MAX + 1);
  localparam int DIV_CELLS = DATA_W;
  localparam int CMP_CELLS = DIVIDER_EXP_MAX + 1;
  localparam logic [PW-1:0]  P_LAST = PW'(PRESCALE_MAX);
  localparam logic [DXW-1:0] D_LAST = DXW'(DIVIDER_EXP_MAX);

  // Registers
  logic [DATA_W-1:0] clk_freq;
  logic [DATA_W-1:0] target;
  scds_state_t       state, state_next;
  logic [PW-1:0]     pcnt;
  logic [DATA_W-1:0] gmin;
  logic [PW-1:0]     best_p;
  logic [DXW-1:0]    best_d;

  // Chain buses
  logic [DIV_CELLS:0] div_valid;
  logic [PW-1:0]      div_p   [0:DIV_CELLS];
  logic [RW-1:0]      div_rem [0:DIV_CELLS];
  logic [DATA_W-1:0]  div_num [0:DIV_CELLS];

  logic [CMP_CELLS:0] cmp_valid;
  logic [PW-1:0]      cmp_p   [0:CMP_CELLS];
  logic [DATA_W-1:0]  cmp_q   [0:CMP_CELLS];
  logic [DATA_W-1:0]  cmp_min [0:CMP_CELLS];
  logic [DXW-1:0]     cmp_d   [0:CMP_CELLS];

  logic accept;
  logic feed;
  logic end_valid;
  logic end_last;
  logic load_out;

  assign accept    = target_valid && !target_stall;
  assign end_valid = cmp_valid[CMP_CELLS];
  assign end_last  = end_valid && (cmp_p[CMP_CELLS] == P_LAST);

  // Clock frequency register
  always_ff @(posedge clk) begin
    if (rst) begin
      clk_freq <= CLOCK_FREQ_RESET;
    end else if (clock_frequency_we) begin
      clk_freq <= clock_frequency;
    end
  end

  // Controller state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and controls
  always_comb begin
    state_next   = state;
    target_stall = 1'b1;
    feed         = 1'b0;
    load_out     = 1'b0;
    case (state)
      ST_IDLE: begin
        target_stall = 1'b0;
        if (target_valid) begin
          state_next = ST_FEED;
        end
      end
      ST_FEED: begin
        feed = 1'b1;
        if (pcnt == P_LAST) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (end_last) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!result_valid || !result_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Prescaler feed counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pcnt <= '0;
    end else if (accept) begin
      pcnt <= '0;
    end else if (feed && pcnt != P_LAST) begin
      pcnt <= pcnt + PW'(1);
    end
  end

  // Target latch
  always_ff @(posedge clk) begin
    if (accept) begin
      target <= target_rate;
    end
  end

  // Quotient pipeline: clock/2 divided by prescaler code plus one
  assign div_valid[0] = feed;
  assign div_p[0]     = pcnt;
  assign div_rem[0]   = '0;
  assign div_num[0]   = {1'b0, clk_freq[DATA_W-1:1]};

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    scds_div_cell #(
      .PW (PW),
      .RW (RW),
      .DW (DATA_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (div_valid[i]),
      .in_p      (div_p[i]),
      .in_rem    (div_rem[i]),
      .in_num    (div_num[i]),
      .out_valid (div_valid[i+1]),
      .out_p     (div_p[i+1]),
      .out_rem   (div_rem[i+1]),
      .out_num   (div_num[i+1])
    );
  end

  // Compare chain over divider exponents
  assign cmp_valid[0] = div_valid[DIV_CELLS];
  assign cmp_p[0]     = div_p[DIV_CELLS];
  assign cmp_q[0]     = div_num[DIV_CELLS];
  assign cmp_min[0]   = SHORT_INIT;
  assign cmp_d[0]     = '0;

  for (genvar j = 0; j < CMP_CELLS; j++) begin : g_cmp
    scds_cmp_cell #(
      .PW  (PW),
      .DXW (DXW),
      .DW  (DATA_W),
      .D   (j)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .target    (target),
      .in_valid  (cmp_valid[j]),
      .in_p      (cmp_p[j]),
      .in_q      (cmp_q[j]),
      .in_min    (cmp_min[j]),
      .in_d      (cmp_d[j]),
      .out_valid (cmp_valid[j+1]),
      .out_p     (cmp_p[j+1]),
      .out_q     (cmp_q[j+1]),
      .out_min   (cmp_min[j+1]),
      .out_d     (cmp_d[j+1])
    );
  end

  // Merge per-prescaler bests in order; earlier code wins ties
  always_ff @(posedge clk) begin
    if (accept) begin
      gmin   <= SHORT_INIT;
      best_p <= P_LAST;
      best_d <= D_LAST;
    end else if (end_valid && cmp_min[CMP_CELLS] < gmin) begin
      gmin   <= cmp_min[CMP_CELLS];
      best_p <= cmp_p[CMP_CELLS];
      best_d <= cmp_d[CMP_CELLS];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      prescale_select  <= PRESCALE_W'(best_p);
      divider_exponent <= DIVEXP_W'(best_d);
    end
  end

`ifndef SYNTH
  // Results leave the compare chain only while waiting
  a_end_in_wait: assert property (@(posedge clk) disable iff (rst)
    end_valid |-> state == ST_WAIT)
    else $error("compare chain output outside wait state");

  // Nothing in flight once idle
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !(|div_valid) && !(|cmp_valid))
    else $error("pipeline not drained in idle");

  // A request starts the feed from prescaler code zero
  a_start_feed: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_FEED && pcnt == '0)
    else $error("feed did not start after request");

  // Last prescaler code out of the chain moves to hold
  a_last_hold: assert property (@(posedge clk) disable iff (rst)
    state == ST_WAIT && end_last |=> state == ST_HOLD)
    else $error("search end missed");

  // Candidate at chain end is bounded by the plain shifted clock
  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    end_valid |-> cmp_q[CMP_CELLS] <= (clk_freq >> (DIVIDER_EXP_MAX + 2)))
    else $error("quotient out of range");
`endif

endmodule
